@@ rtl/ctok_pkg.sv @@
// Package for the command-line tokenizer: result kinds, quote states,
// the result record and the byte constants.
// No dependencies.
`default_nettype none

package ctok_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_ARG_END  = 2'd1,
        KIND_LINE_END = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_DOUBLE = 2'd1,
        QM_SINGLE = 2'd2
    } quote_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [15:0] arg_count;
        logic        last;
    } result_t;

    localparam logic [7:0]  ESCAPE_RESET = 8'h5E;
    localparam logic [7:0]  CH_NUL       = 8'h00;
    localparam logic [7:0]  CH_DQUOTE    = 8'h22;
    localparam logic [7:0]  CH_SQUOTE    = 8'h27;
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam logic [7:0]  CH_TAB       = 8'h09;
    localparam logic [7:0]  CH_LF        = 8'h0A;
    localparam logic [7:0]  CH_CR        = 8'h0D;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

@@ rtl/command_line_tokenizer.sv @@
// Command-line tokenizer: parser state, next-state logic and a four-entry result queue.
// Uses ctok_pkg for types and constants.
// A result is written into the queue register on its input transaction and is offered from the queue head.
// Throughput: one input byte per cycle while the queue has room for two results.
// Reset clears the parser state, the queue and sets the escape byte to '^'.
`default_nettype none

module command_line_tokenizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] line_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] data, [23:8] arg_count
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast
);

    logic [7:0]             escape_reg;
    ctok_pkg::quote_t       quote_reg, quote_next;
    logic                   esc_reg, esc_next;
    logic                   nonempty_reg, nonempty_next;
    logic [15:0]            args_reg, args_next;

    ctok_pkg::result_t      queue_reg [ctok_pkg::QUEUE_DEPTH];
    logic [ctok_pkg::PTR_W-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_alt;
    logic [ctok_pkg::CNT_W-1:0] fill_reg, fill_next;

    ctok_pkg::result_t      res0, res1;
    logic [1:0]             push_n;
    logic                   in_fire, out_fire;
    logic [7:0]             c;
    logic [15:0]            args_inc;
    logic [7:0]             closer;
    logic                   is_ws;

    assign c        = s_axis_tdata;
    assign args_inc = (args_reg != ctok_pkg::COUNT_MAX) ? args_reg + 16'd1 : args_reg;
    assign closer   = (quote_reg == ctok_pkg::QM_DOUBLE) ? ctok_pkg::CH_DQUOTE
                                                         : ctok_pkg::CH_SQUOTE;
    assign is_ws    = (c == ctok_pkg::CH_SPACE) || (c == ctok_pkg::CH_TAB) ||
                      (c == ctok_pkg::CH_LF) || (c == ctok_pkg::CH_CR);

    assign s_axis_tready = (fill_reg <= ctok_pkg::CNT_W'(ctok_pkg::QUEUE_DEPTH - 2));
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (fill_reg != '0);
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        quote_next    = quote_reg;
        esc_next      = esc_reg;
        nonempty_next = nonempty_reg;
        args_next     = args_reg;
        push_n        = 2'd0;
        res0          = '{kind: ctok_pkg::KIND_BYTE, data: c, arg_count: args_reg, last: 1'b1};
        res1          = '{kind: ctok_pkg::KIND_LINE_END, data: 8'd0, arg_count: args_reg,
                          last: 1'b1};
        if (c == ctok_pkg::CH_NUL)
        begin
            if (nonempty_reg)
            begin
                res0   = '{kind: ctok_pkg::KIND_ARG_END, data: 8'd0, arg_count: args_inc,
                           last: 1'b0};
                res1.arg_count = args_inc;
                push_n = 2'd2;
            end
            else
            begin
                res0   = '{kind: ctok_pkg::KIND_LINE_END, data: 8'd0, arg_count: args_reg,
                           last: 1'b1};
                push_n = 2'd1;
            end
            quote_next    = ctok_pkg::QM_NONE;
            esc_next      = 1'b0;
            nonempty_next = 1'b0;
            args_next     = 16'd0;
        end
        else
        begin
            if (c == escape_reg)
            begin
                if (esc_reg)
                begin
                    nonempty_next = 1'b1;
                    push_n        = 2'd1;
                end
            end
            else if (quote_reg != ctok_pkg::QM_NONE)
            begin
                if (c == closer && !esc_reg)
                begin
                    quote_next = ctok_pkg::QM_NONE;
                end
                else
                begin
                    nonempty_next = 1'b1;
                    push_n        = 2'd1;
                end
            end
            else if (c == ctok_pkg::CH_DQUOTE || c == ctok_pkg::CH_SQUOTE)
            begin
                if (!esc_reg)
                begin
                    quote_next = (c == ctok_pkg::CH_DQUOTE) ? ctok_pkg::QM_DOUBLE
                                                            : ctok_pkg::QM_SINGLE;
                end
                else
                begin
                    nonempty_next = 1'b1;
                    push_n        = 2'd1;
                end
            end
            else if (is_ws)
            begin
                if (!esc_reg)
                begin
                    if (nonempty_reg)
                    begin
                        args_next = args_inc;
                        res0      = '{kind: ctok_pkg::KIND_ARG_END, data: 8'd0,
                                      arg_count: args_inc, last: 1'b1};
                        push_n    = 2'd1;
                    end
                    nonempty_next = 1'b0;
                end
                else
                begin
                    nonempty_next = 1'b1;
                    push_n        = 2'd1;
                end
            end
            else
            begin
                nonempty_next = 1'b1;
                push_n        = 2'd1;
            end
            esc_next = (c == escape_reg);
        end
    end

    assign wr_ptr_alt = wr_ptr_reg + ctok_pkg::PTR_W'(1);

    always_comb
    begin
        fill_next = fill_reg;
        if (in_fire)
        begin
            fill_next = fill_next + ctok_pkg::CNT_W'(push_n);
        end
        if (out_fire)
        begin
            fill_next = fill_next - ctok_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg   <= ctok_pkg::ESCAPE_RESET;
            quote_reg    <= ctok_pkg::QM_NONE;
            esc_reg      <= 1'b0;
            nonempty_reg <= 1'b0;
            args_reg     <= 16'd0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                escape_reg <= cfg_wdata;
            end
            if (in_fire)
            begin
                quote_reg    <= quote_next;
                esc_reg      <= esc_next;
                nonempty_reg <= nonempty_next;
                args_reg     <= args_next;
                wr_ptr_reg   <= wr_ptr_reg + ctok_pkg::PTR_W'(push_n);
            end
            if (out_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + ctok_pkg::PTR_W'(1);
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (in_fire && push_n == 2'd2)
        begin
            queue_reg[wr_ptr_alt] <= res1;
        end
    end

    ctok_pkg::result_t head;
    assign head         = queue_reg[rd_ptr_reg];
    assign m_axis_tdata = {head.arg_count, head.data};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for command_line_tokenizer: streams command-line bytes,
// predicts argument bytes, argument ends and line ends, and checks every result.
// Depends on ctok_pkg and command_line_tokenizer from the rtl folder.
module tb;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PHASE_ITEMS = 125;
    localparam int unsigned NUM_PHASES  = 7;
    localparam int unsigned TAIL_ARGS   = 30;

    localparam logic [7:0] DIRECTED [23] = '{
        8'h61, 8'h62, ctok_pkg::CH_SPACE, ctok_pkg::ESCAPE_RESET, ctok_pkg::CH_DQUOTE,
        ctok_pkg::ESCAPE_RESET, ctok_pkg::ESCAPE_RESET, ctok_pkg::ESCAPE_RESET,
        ctok_pkg::CH_DQUOTE, ctok_pkg::CH_SPACE,
        8'h78, ctok_pkg::CH_TAB, ctok_pkg::CH_DQUOTE, ctok_pkg::ESCAPE_RESET,
        ctok_pkg::CH_SPACE,
        ctok_pkg::CH_LF, 8'hFF, 8'h80, ctok_pkg::CH_CR, ctok_pkg::CH_SQUOTE,
        8'h71, ctok_pkg::CH_NUL, ctok_pkg::CH_NUL
    };

    class token_checker;
        logic [7:0]        escape_byte;
        ctok_pkg::quote_t  quote;
        bit                prev_escape;
        bit                arg_open;
        logic [15:0]       args_done;
        ctok_pkg::result_t queued[$];
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       lines;
        int unsigned       top_count;

        function new();
            escape_byte = ctok_pkg::ESCAPE_RESET;
            quote       = ctok_pkg::QM_NONE;
            prev_escape = 1'b0;
            arg_open    = 1'b0;
            args_done   = '0;
            errors      = 0;
            checked     = 0;
            lines       = 0;
            top_count   = 0;
        endfunction

        function void push(ctok_pkg::kind_t k, logic [7:0] d);
            ctok_pkg::result_t r;
            if (k == ctok_pkg::KIND_BYTE)
                arg_open = 1'b1;
            if (k == ctok_pkg::KIND_ARG_END && args_done != ctok_pkg::COUNT_MAX)
                args_done = args_done + 16'd1;
            r.kind      = k;
            r.data      = d;
            r.arg_count = args_done;
            r.last      = 1'b0;
            queued.push_back(r);
        endfunction

        function void note_byte(logic [7:0] c);
            int unsigned start_size;
            bit          esc;
            logic [7:0]  closer;
            start_size = queued.size();
            esc        = prev_escape;
            if (c == ctok_pkg::CH_NUL) begin
                if (arg_open)
                    push(ctok_pkg::KIND_ARG_END, 8'h00);
                push(ctok_pkg::KIND_LINE_END, 8'h00);
                quote       = ctok_pkg::QM_NONE;
                prev_escape = 1'b0;
                arg_open    = 1'b0;
                args_done   = '0;
                lines++;
            end else begin
                if (c == escape_byte) begin
                    if (esc)
                        push(ctok_pkg::KIND_BYTE, c);
                end else if (quote != ctok_pkg::QM_NONE) begin
                    closer = (quote == ctok_pkg::QM_DOUBLE) ? ctok_pkg::CH_DQUOTE
                                                            : ctok_pkg::CH_SQUOTE;
                    if (c == closer && !esc)
                        quote = ctok_pkg::QM_NONE;
                    else
                        push(ctok_pkg::KIND_BYTE, c);
                end else if (c == ctok_pkg::CH_DQUOTE || c == ctok_pkg::CH_SQUOTE) begin
                    if (!esc)
                        quote = (c == ctok_pkg::CH_DQUOTE) ? ctok_pkg::QM_DOUBLE
                                                           : ctok_pkg::QM_SINGLE;
                    else
                        push(ctok_pkg::KIND_BYTE, c);
                end else if (c == ctok_pkg::CH_SPACE || c == ctok_pkg::CH_TAB ||
                             c == ctok_pkg::CH_LF || c == ctok_pkg::CH_CR) begin
                    if (!esc) begin
                        if (arg_open)
                            push(ctok_pkg::KIND_ARG_END, 8'h00);
                        arg_open = 1'b0;
                    end else begin
                        push(ctok_pkg::KIND_BYTE, c);
                    end
                end else begin
                    push(ctok_pkg::KIND_BYTE, c);
                end
                prev_escape = (c == escape_byte);
            end
            if (queued.size() > start_size)
                queued[queued.size() - 1].last = 1'b1;
        endfunction

        function void check_token(ctok_pkg::kind_t k, logic [7:0] d, logic [15:0] n,
                                  logic l);
            ctok_pkg::result_t want;
            checked++;
            if (n > top_count)
                top_count = n;
            if (queued.size() == 0) begin
                errors++;
                $error("unexpected result: kind %0d data %0h count %0d last %0b",
                       k, d, n, l);
                return;
            end
            want = queued.pop_front();
            if (want.kind != k) begin
                errors++;
                $error("kind: expected %0d, actual %0d", want.kind, k);
            end
            if (want.data != d) begin
                errors++;
                $error("data: expected %0h, actual %0h", want.data, d);
            end
            if (want.arg_count != n) begin
                errors++;
                $error("arg_count: expected %0d, actual %0d", want.arg_count, n);
            end
            if (want.last != l) begin
                errors++;
                $error("last: expected %0b, actual %0b", want.last, l);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    token_checker tokens;
    bit           idle_on;
    bit           hold_req;
    int unsigned  bytes_sent;
    int unsigned  quiet;
    int unsigned  stall_left;

    command_line_tokenizer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tokens.note_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic write_escape(input logic [7:0] value);
        s_axis_tvalid = 1'b0;
        while (tokens.queued.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        tokens.escape_byte = value;
    endtask

    function automatic logic [7:0] pick_line_byte(logic [7:0] esc);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 8'($urandom_range(8'h21, 8'h7E));
        else if (r < 60)
            case (r % 4)
                0: return ctok_pkg::CH_SPACE;
                1: return ctok_pkg::CH_TAB;
                2: return ctok_pkg::CH_LF;
                default: return ctok_pkg::CH_CR;
            endcase
        else if (r < 72)
            return esc;
        else if (r < 84)
            return (r % 2) ? ctok_pkg::CH_DQUOTE : ctok_pkg::CH_SQUOTE;
        else
            return 8'($urandom_range(1, 255));
    endfunction

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready = 1'b0;
                stall_left    = $urandom_range(1, 14) - 1;
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                tokens.check_token(ctok_pkg::kind_t'(m_axis_tuser), m_axis_tdata[7:0],
                                   m_axis_tdata[23:8], m_axis_tlast);
        end
    end

    initial
    begin
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned sent;
        int unsigned len;
        logic [7:0]  esc;
        tokens        = new();
        cfg_we        = 1'b0;
        cfg_wdata     = 8'h00;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        bytes_sent    = 0;
        rst_n         = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i]);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: esc = ctok_pkg::ESCAPE_RESET;
                1: esc = 8'h00;
                2: esc = 8'hFF;
                3: esc = ctok_pkg::CH_SPACE;
                4: esc = ctok_pkg::CH_DQUOTE;
                5: esc = ctok_pkg::CH_SQUOTE;
                default: esc = 8'($urandom_range(1, 255));
            endcase
            write_escape(esc);
            idle_on = (phase % 3 != 2);
            if (phase == 1)
                hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    len = $urandom_range(1, 8);
                    repeat (len) send_byte(8'($urandom_range(0, 255)));
                end
                else
                begin
                    len = $urandom_range(0, 24);
                    repeat (len) send_byte(pick_line_byte(esc));
                    send_byte(ctok_pkg::CH_NUL);
                    len++;
                end
                sent += len;
            end
        end

        // Tail: one line of many short arguments with no idling on either side.
        idle_on = 1'b0;
        write_escape(ctok_pkg::ESCAPE_RESET);
        send_byte(ctok_pkg::CH_NUL);
        repeat (TAIL_ARGS)
        begin
            send_byte(8'h78);
            send_byte(ctok_pkg::CH_SPACE);
        end
        send_byte(8'h79);
        send_byte(ctok_pkg::CH_NUL);

        s_axis_tvalid = 1'b0;
        while (tokens.queued.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Run covered %0d bytes over %0d lines with %0d escape settings.",
                 bytes_sent, tokens.lines, NUM_PHASES + 1);
        $display("Checked %0d results; highest argument count seen %0d.",
                 tokens.checked, tokens.top_count);
        if (tokens.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
